/* design/qfe_pkg.sv */
// ----------------------------------------------------------------------------
// qfe_pkg
// Shared types, constants and helpers of the query field extractor.
// ----------------------------------------------------------------------------
package qfe_pkg;

  // Default tag capacity in characters
  localparam int QFE_MAX_TAG_CHARS = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_TAG_CHARS  = 2'd0;
  localparam logic [1:0] REG_TAG_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_VALUE  = 2'd2;

  localparam logic [15:0] MAX_VALUE_RESET = 16'hFFFF;

  // Characters of interest
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [7:0] CHAR_EQ  = 8'h3D;
  localparam logic [7:0] CHAR_PCT = 8'h25;

  // Done report status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;
  localparam logic [1:0] ST_EMPTY_TAG  = 2'd3;

  // Result kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value_byte;
    logic [1:0]  status;
    logic [15:0] value_length;
    logic        final_res;
  } res_t;

  // Up to two results per input byte
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } step_out_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'h0A)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'h0A)};
    end
    return r;
  endfunction

  function automatic res_t make_value(input logic [7:0] b);
    res_t r;
    r = '0;
    r.kind       = KIND_VALUE;
    r.value_byte = b;
    return r;
  endfunction

  // Length is reported only with status found
  function automatic res_t make_done(input logic [1:0] st, input logic [15:0] len);
    res_t r;
    r = '0;
    r.kind         = KIND_DONE;
    r.status       = st;
    r.value_length = (st == ST_FOUND) ? len : 16'd0;
    r.final_res    = 1'b1;
    return r;
  endfunction

endpackage

/* design/query_field_extractor_top.sv */
// ----------------------------------------------------------------------------
// query_field_extractor_top
// Looks up one key in a URL-encoded query string and streams its value.
// ----------------------------------------------------------------------------
// Usage:
//   Send the query string on the s_axis channel, one byte per transaction,
//   ended by a zero byte. The decoded value bytes of the key equal to the
//   configured tag leave on m_axis (tuser low), followed by one done report
//   (tuser high, tlast high) carrying status and value length. Bytes after
//   the done report are dropped until the zero byte that ends the string.
//   Program tag, tag length and length limit over the APB port at 8*index
//   while no lookup is under way.
// Timing:
//   A byte is held in an input register, then the lookup logic updates its
//   state and writes its results into a four-entry result queue, whose head
//   drives m_axis. One byte per cycle is sustained; the result queue sets
//   the rate, taking a byte only while it has room for two results.
// Reset and stalls:
//   Reset clears the queue, the input register and the lookup state, and
//   restores the register defaults. When m_axis stalls the queue fills and
//   s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module query_field_extractor_top
  import qfe_pkg::*;
#(
  parameter int MAX_TAG_CHARS = QFE_MAX_TAG_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  // Query byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] value_byte, [9:8] status,
                                      // [25:10] value_length, [31:26] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,   // final_res
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int TAG_W = MAX_TAG_CHARS * 8;

  // Configuration registers
  logic [TAG_W-1:0] tag_chars;
  logic [3:0]       tag_length;
  logic [15:0]      max_value_length;

  // Input register
  logic       in_valid;
  logic [7:0] in_char;

  logic       has_room;
  logic       advance;
  step_out_t  step_out;
  res_t       out_res;
  logic [1:0] reg_index;
  logic       reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_chars        <= '0;
      tag_length       <= 4'd0;
      max_value_length <= MAX_VALUE_RESET;
    end else if (reg_write) begin
      case (reg_index)
        REG_TAG_CHARS:  tag_chars        <= pwdata[TAG_W-1:0];
        REG_TAG_LENGTH: tag_length       <= pwdata[3:0];
        REG_MAX_VALUE:  max_value_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_TAG_CHARS:  prdata = 64'(tag_chars);
      REG_TAG_LENGTH: prdata = 64'(tag_length);
      REG_MAX_VALUE:  prdata = 64'(max_value_length);
      default:        prdata = 64'd0;
    endcase
  end

  // Advance the held byte once the queue can take both of its results
  assign advance       = in_valid && has_room;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  qfe_step #(
    .MAX_TAG_CHARS(MAX_TAG_CHARS)
  ) u_step (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .char_in          (in_char),
    .tag_chars        (tag_chars),
    .tag_length       (tag_length),
    .max_value_length (max_value_length),
    .step_out         (step_out)
  );

  qfe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_out),
    .has_room  (has_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.value_length, out_res.status, out_res.value_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.final_res;

endmodule

/* design/qfe_step.sv */
// ----------------------------------------------------------------------------
// qfe_step
// Lookup state machine: one query byte per cycle while advance is high, up to two results.
// ----------------------------------------------------------------------------
module qfe_step
  import qfe_pkg::*;
#(
  parameter int MAX_TAG_CHARS = QFE_MAX_TAG_CHARS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [7:0]                 char_in,
  input  logic [MAX_TAG_CHARS*8-1:0] tag_chars,
  input  logic [3:0]                 tag_length,
  input  logic [15:0]                max_value_length,
  output step_out_t                  step_out
);

  typedef enum logic [8:0] {
    PH_START    = 9'b000000001,
    PH_KEY      = 9'b000000010,
    PH_KEY_ESC1 = 9'b000000100,
    PH_KEY_ESC2 = 9'b000001000,
    PH_SKIP     = 9'b000010000,
    PH_VALUE    = 9'b000100000,
    PH_VAL_ESC1 = 9'b001000000,
    PH_VAL_ESC2 = 9'b010000000,
    PH_DRAIN    = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  tag_position, tag_position_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [15:0] emitted_count, emitted_count_next;

  logic [3:0]  eff_len;
  logic [4:0]  hex;
  logic [3:0]  cmp_pos;
  logic [7:0]  cmp_byte;
  logic        tag_hit;
  logic [7:0]  esc_byte;
  logic [15:0] count_inc;
  phase_t      done_phase;

  assign eff_len    = (tag_length > 4'(MAX_TAG_CHARS)) ? 4'(MAX_TAG_CHARS) : tag_length;
  assign hex        = hex_decode(char_in);
  assign esc_byte   = {high_nibble, hex[3:0]};
  assign cmp_pos    = (phase == PH_START) ? 4'd0 : tag_position;
  assign cmp_byte   = (phase == PH_KEY_ESC2) ? esc_byte : char_in;
  assign count_inc  = emitted_count + 16'd1;
  assign done_phase = (char_in == CHAR_NUL) ? PH_START : PH_DRAIN;

  always_comb begin
    tag_hit = 1'b0;
    for (int i = 0; i < MAX_TAG_CHARS; i++) begin
      if (cmp_pos == 4'(i) && 4'(i) < eff_len && tag_chars[8*i +: 8] == cmp_byte) begin
        tag_hit = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    tag_position_next  = tag_position;
    high_nibble_next   = high_nibble;
    emitted_count_next = emitted_count;
    step_out           = '0;
    case (phase)
      PH_START, PH_KEY: begin
        tag_position_next = cmp_pos;
        if (phase == PH_START && eff_len == 4'd0) begin
          step_out.count    = 2'd1;
          step_out.res0     = make_done(ST_EMPTY_TAG, 16'd0);
          phase_next        = done_phase;
          tag_position_next = 4'd0;
        end else begin
          phase_next = PH_KEY;
          if (char_in == CHAR_NUL) begin
            step_out.count    = 2'd1;
            step_out.res0     = make_done(ST_NOT_FOUND, 16'd0);
            phase_next        = PH_START;
            tag_position_next = 4'd0;
          end else if (char_in == CHAR_AMP) begin
            tag_position_next = 4'd0;
          end else if (char_in == CHAR_EQ) begin
            if (cmp_pos == eff_len) begin
              emitted_count_next = 16'd0;
              if (max_value_length == 16'd0) begin
                step_out.count    = 2'd1;
                step_out.res0     = make_done(ST_FOUND, 16'd0);
                phase_next        = PH_DRAIN;
                tag_position_next = 4'd0;
              end else begin
                phase_next = PH_VALUE;
              end
            end else begin
              phase_next = PH_SKIP;
            end
          end else if (char_in == CHAR_PCT) begin
            phase_next = PH_KEY_ESC1;
          end else if (tag_hit) begin
            tag_position_next = cmp_pos + 4'd1;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_KEY_ESC1, PH_VAL_ESC1: begin
        if (!hex[4]) begin
          step_out.count    = 2'd1;
          step_out.res0     = make_done(ST_BAD_ESCAPE, 16'd0);
          phase_next        = done_phase;
          tag_position_next = 4'd0;
        end else begin
          high_nibble_next = hex[3:0];
          phase_next       = (phase == PH_KEY_ESC1) ? PH_KEY_ESC2 : PH_VAL_ESC2;
        end
      end
      PH_KEY_ESC2: begin
        if (!hex[4]) begin
          step_out.count    = 2'd1;
          step_out.res0     = make_done(ST_BAD_ESCAPE, 16'd0);
          phase_next        = done_phase;
          tag_position_next = 4'd0;
        end else if (tag_hit) begin
          tag_position_next = tag_position + 4'd1;
          phase_next        = PH_KEY;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (char_in == CHAR_NUL) begin
          step_out.count    = 2'd1;
          step_out.res0     = make_done(ST_NOT_FOUND, 16'd0);
          phase_next        = PH_START;
          tag_position_next = 4'd0;
        end else if (char_in == CHAR_AMP) begin
          tag_position_next = 4'd0;
          phase_next        = PH_KEY;
        end
      end
      PH_VALUE, PH_VAL_ESC2: begin
        if (phase == PH_VAL_ESC2 && !hex[4]) begin
          step_out.count    = 2'd1;
          step_out.res0     = make_done(ST_BAD_ESCAPE, 16'd0);
          phase_next        = done_phase;
          tag_position_next = 4'd0;
        end else if (phase == PH_VALUE && (char_in == CHAR_NUL || char_in == CHAR_AMP)) begin
          step_out.count    = 2'd1;
          step_out.res0     = make_done(ST_FOUND, emitted_count);
          phase_next        = done_phase;
          tag_position_next = 4'd0;
        end else if (phase == PH_VALUE && char_in == CHAR_PCT) begin
          phase_next = PH_VAL_ESC1;
        end else begin
          // Emit one decoded byte; close the lookup at the length limit
          step_out.count     = 2'd1;
          step_out.res0      = make_value((phase == PH_VALUE) ? char_in : esc_byte);
          emitted_count_next = count_inc;
          phase_next         = PH_VALUE;
          if (count_inc >= max_value_length) begin
            step_out.count    = 2'd2;
            step_out.res1     = make_done(ST_FOUND, count_inc);
            phase_next        = done_phase;
            tag_position_next = 4'd0;
          end
        end
      end
      PH_DRAIN: begin
        if (char_in == CHAR_NUL) begin
          phase_next        = PH_START;
          tag_position_next = 4'd0;
        end
      end
      default: begin
        phase_next        = PH_START;
        tag_position_next = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      tag_position  <= 4'd0;
      high_nibble   <= 4'd0;
      emitted_count <= 16'd0;
    end else if (advance) begin
      phase         <= phase_next;
      tag_position  <= tag_position_next;
      high_nibble   <= high_nibble_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

/* design/qfe_out_fifo.sv */
// ----------------------------------------------------------------------------
// qfe_out_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
module qfe_out_fifo
  import qfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_out_t push_data,
  output logic      has_room,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_data
);

  res_t       entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] push_count;
  logic       pop;

  assign push_count = push ? push_data.count : 2'd0;
  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 3'd0);
  assign out_data   = entries[rd_ptr];
  assign has_room   = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_data.res0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push_data.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push_count) - 3'(pop);
    end
  end

endmodule
